### rtl/core/zigzag_varint_delta_codec_defines.svh
// Assertion macros shared by the codec RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ZIGZAG_VARINT_DELTA_CODEC_DEFINES_SVH
`define ZIGZAG_VARINT_DELTA_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define ZVD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("zvd assertion failed");
// Condition that must never be seen out of reset.
`define ZVD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("zvd forbidden condition seen");
`else
`define ZVD_ASSERT(lbl, clk, rst_n, prop)
`define ZVD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/core/zvd_pkg.sv
// Shared types and constants for the zigzag / LEB128 codec.
// No dependencies; used by every module of the block.
package zvd_pkg;

    localparam int WORD_BITS   = 64;
    localparam int VAL_W       = 64;
    localparam int COORD_W     = 32;
    localparam int BYTE_W      = 8;
    localparam int GROUP_BITS  = 7;
    localparam int GS_W        = $clog2(WORD_BITS + GROUP_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VAL_W-1:0] WORD_MASK = {VAL_W{1'b1}} >> (VAL_W - WORD_BITS);
    localparam logic [VAL_W-1:0] WORD_SIGN = VAL_W'(1) << (WORD_BITS - 1);
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        MODE_ENC_RAW = 3'd0,
        MODE_ENC_ZZ  = 3'd1,
        MODE_ENC_X   = 3'd2,
        MODE_ENC_Y   = 3'd3,
        MODE_DEC_RAW = 3'd4,
        MODE_DEC_ZZ  = 3'd5,
        MODE_DEC_X   = 3'd6,
        MODE_DEC_Y   = 3'd7
    } mode_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [VAL_W-1:0]  value_in;
        logic [BYTE_W-1:0] byte_in;
    } in_item_t;

    typedef struct packed {
        logic              is_value;
        logic [BYTE_W-1:0] byte_out;
        logic [VAL_W-1:0]  value_out;
        logic              last;
    } out_item_t;

    // Work handed from the front to the back: a word to serialize or a
    // finished decoded value.
    typedef struct packed {
        logic             is_value;
        logic [VAL_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

### rtl/core/zvd_front.sv
// Front end: accepts items, keeps the coordinate and decode state and
// produces one command per encode item or per final decode byte. Uses zvd_pkg.
`include "zigzag_varint_delta_codec_defines.svh"
module zvd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  zvd_pkg::in_item_t item,
    input  logic              q_full,
    output logic              q_push,
    output zvd_pkg::cmd_t     q_cmd
);
    import zvd_pkg::*;

    logic [COORD_W-1:0] last_x_reg, last_x_next;
    logic [COORD_W-1:0] last_y_reg, last_y_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic [GS_W-1:0]    gs_reg, gs_next;

    logic               accept;
    logic               is_dec;
    logic               more;
    logic [VAL_W-1:0]   word;
    logic [VAL_W-1:0]   word_s;
    logic [VAL_W-1:0]   zz_word;
    logic [COORD_W-1:0] coord;
    logic [COORD_W-1:0] base;
    logic [VAL_W-1:0]   diff;
    logic [VAL_W-1:0]   zz_diff;
    logic               in_range;
    logic [VAL_W-1:0]   acc_upd;
    logic [GS_W-1:0]    gs_upd;
    logic [VAL_W-1:0]   unmap;
    logic [VAL_W:0]     sum;
    logic               sat_hi;
    logic               sat_lo;
    logic [COORD_W-1:0] sat;
    logic [VAL_W-1:0]   dec_res;
    logic [VAL_W-1:0]   enc_word;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign is_dec = item.mode[2];
    assign more   = item.byte_in[BYTE_W-1];

    // encode side
    assign word    = item.value_in & WORD_MASK;
    assign word_s  = (word ^ WORD_SIGN) - WORD_SIGN;
    assign zz_word = ((word_s << 1) ^ {VAL_W{word_s[VAL_W-1]}}) & WORD_MASK;
    assign coord   = item.value_in[COORD_W-1:0];
    assign base    = item.mode[0] ? last_y_reg : last_x_reg;
    assign diff    = {{(VAL_W-COORD_W){coord[COORD_W-1]}}, coord}
                   - {{(VAL_W-COORD_W){base[COORD_W-1]}}, base};
    assign zz_diff = (diff << 1) ^ {VAL_W{diff[VAL_W-1]}};

    // decode side: groups past the word width are dropped
    assign in_range = gs_reg < GS_W'(WORD_BITS);
    assign acc_upd  = in_range
                    ? ((acc_reg | (VAL_W'(item.byte_in[GROUP_BITS-1:0]) << gs_reg)) & WORD_MASK)
                    : acc_reg;
    assign gs_upd   = in_range ? gs_reg + GS_W'(GROUP_BITS) : gs_reg;
    assign unmap    = (acc_upd >> 1) ^ {VAL_W{acc_upd[0]}};

    assign sum    = {unmap[VAL_W-1], unmap}
                  + {{(VAL_W+1-COORD_W){base[COORD_W-1]}}, base};
    assign sat_hi = !sum[VAL_W] && (sum[VAL_W-1:COORD_W-1] != '0);
    assign sat_lo = sum[VAL_W] && (sum[VAL_W-1:COORD_W-1] != '1);
    assign sat    = sat_hi ? COORD_MAX : (sat_lo ? COORD_MIN : sum[COORD_W-1:0]);

    always_comb
    begin
        enc_word = word;
        dec_res  = acc_upd;
        case (mode_t'(item.mode))
            MODE_ENC_RAW: enc_word = word;
            MODE_ENC_ZZ:  enc_word = zz_word;
            MODE_ENC_X,
            MODE_ENC_Y:   enc_word = zz_diff;
            MODE_DEC_RAW: dec_res  = acc_upd;
            MODE_DEC_ZZ:  dec_res  = unmap & WORD_MASK;
            MODE_DEC_X,
            MODE_DEC_Y:   dec_res  = {{(VAL_W-COORD_W){sat[COORD_W-1]}}, sat};
            default:      dec_res  = acc_upd;
        endcase
    end

    assign q_push       = accept && (!is_dec || !more);
    assign q_cmd.is_value = is_dec;
    assign q_cmd.data     = is_dec ? dec_res : enc_word;

    always_comb
    begin
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        acc_next    = acc_reg;
        gs_next     = gs_reg;
        if (accept)
        begin
            if (!is_dec)
            begin
                if (item.mode[1])
                begin
                    if (item.mode[0])
                        last_y_next = coord;
                    else
                        last_x_next = coord;
                end
            end
            else if (more)
            begin
                acc_next = acc_upd;
                gs_next  = gs_upd;
            end
            else
            begin
                acc_next = '0;
                gs_next  = '0;
                if (item.mode[1])
                begin
                    if (item.mode[0])
                        last_y_next = sat;
                    else
                        last_x_next = sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            acc_reg    <= '0;
            gs_reg     <= '0;
        end
        else
        begin
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            acc_reg    <= acc_next;
            gs_reg     <= gs_next;
        end
    end

    `ZVD_NEVER(a_gs_bound, clk, rst_n, gs_reg > GS_W'(WORD_BITS + GROUP_BITS - 1))
    `ZVD_ASSERT(a_word_ends, clk, rst_n,
        accept && is_dec && !more |=> (gs_reg == '0) && (acc_reg == '0))

endmodule

### rtl/core/zvd_queue.sv
// Short command queue between the front and the back of the codec.
// Uses zvd_pkg for the command type and depth.
`include "zigzag_varint_delta_codec_defines.svh"
module zvd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  zvd_pkg::cmd_t    wr_cmd,
    output logic             full,
    input  logic             rd,
    output zvd_pkg::q_head_t head
);
    import zvd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_wr      = wr && !full;
    assign do_rd      = rd && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    `ZVD_NEVER(a_q_overflow, clk, rst_n, wr && full)
    `ZVD_ASSERT(a_q_ptrs, clk, rst_n,
        (count_reg == '0) || full || (wr_ptr_reg != rd_ptr_reg))

endmodule

### rtl/core/zvd_back.sv
// Back end: turns queued commands into result words, one per cycle when not stalled,
// through an output register. Encode words become LEB128 bytes. Uses zvd_pkg.
`include "zigzag_varint_delta_codec_defines.svh"
module zvd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  zvd_pkg::q_head_t   head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output zvd_pkg::out_item_t result
);
    import zvd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_ENC  = 3'b010,
        B_VAL  = 3'b100
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [VAL_W-1:0] data_reg, data_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             emit_ok;
    logic             final_byte;
    logic             done;
    logic             take;

    assign emit_ok    = !out_valid_reg || pop;
    assign final_byte = data_reg[VAL_W-1:GROUP_BITS] == '0;
    assign done       = emit_ok && ((state_reg == B_VAL) || (state_reg == B_ENC && final_byte));
    assign take       = head.valid && ((state_reg == B_IDLE) || done);
    assign q_pop      = take;
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
            end
            B_ENC:
            begin
                if (emit_ok)
                begin
                    out_valid_next    = 1'b1;
                    out_next.is_value = 1'b0;
                    out_next.byte_out = {!final_byte, data_reg[GROUP_BITS-1:0]};
                    out_next.value_out = '0;
                    out_next.last     = final_byte;
                    data_next         = data_reg >> GROUP_BITS;
                    if (final_byte)
                        state_next = B_IDLE;
                end
            end
            B_VAL:
            begin
                if (emit_ok)
                begin
                    out_valid_next     = 1'b1;
                    out_next.is_value  = 1'b1;
                    out_next.byte_out  = '0;
                    out_next.value_out = data_reg;
                    out_next.last      = 1'b1;
                    state_next         = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (take)
        begin
            state_next = head.cmd.is_value ? B_VAL : B_ENC;
            data_next  = head.cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        out_reg  <= out_next;
    end

    `ZVD_ASSERT(a_cont_bit, clk, rst_n,
        out_valid_reg && !out_reg.is_value |-> (out_reg.byte_out[BYTE_W-1] != out_reg.last))
    `ZVD_ASSERT(a_value_form, clk, rst_n,
        out_valid_reg && out_reg.is_value |-> out_reg.last && (out_reg.byte_out == '0))

endmodule

### rtl/core/zigzag_varint_delta_codec.sv
// Zigzag / LEB128 varint codec with coordinate deltas, top level.
// Input side is a queue: present item and raise push while full is low.
// Result side is a queue: while empty is low the oldest result is on result;
// raise pop to take it.
// Modes 0..3 encode value_in into 1 to 10 byte results (last on the final
// one); modes 4..7 take one byte_in per item and give one value result on a
// byte with bit 7 clear, none on a continuation byte.
// The first result of an item passes the command queue, the back-end state
// register and the output register before it shows. Throughput: decode bytes
// go in at one per cycle while full is low. An encode item holds the output
// serializer until its ceil(bits/7) bytes (1..10) are out; the input keeps
// flowing until the two-entry command queue fills. A stalled receiver holds
// the output register; the serializer and then the queue back up, and full rises.
// Reset clears the stored x/y, the decode accumulator and all queues; no
// clearing pass is needed.
// Depends on zvd_pkg, zvd_front, zvd_queue and zvd_back.
module zigzag_varint_delta_codec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  zvd_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output zvd_pkg::out_item_t  result
);
    import zvd_pkg::*;

    logic    q_full;
    logic    q_push;
    cmd_t    q_cmd;
    logic    q_pop;
    q_head_t q_head;

    zvd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    zvd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_cmd (q_cmd),
        .full   (q_full),
        .rd     (q_pop),
        .head   (q_head)
    );

    zvd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

### tb/sv/zigzag_varint_delta_codec_checker.sv
// Result checker for the zigzag / LEB128 varint codec.
// Predicts result words from accepted input words; depends on zvd_pkg.
module zigzag_varint_delta_codec_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  zvd_pkg::in_item_t  item,
    input  logic               empty,
    input  logic               pop,
    input  zvd_pkg::out_item_t result,
    output int                 mismatches,
    output int                 waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import zvd_pkg::*;

    localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    logic [VAL_W-1:0]   acc;
    int                 group_pos;
    int                 fail_n;
    out_item_t          due_words[$];

    initial
    begin
        mismatches = 0;
        waiting    = 0;
        fail_n     = 0;
    end

    function automatic logic [VAL_W-1:0] zz_fold(logic [VAL_W-1:0] s);
        return (s << 1) ^ {VAL_W{s[VAL_W-1]}};
    endfunction

    function automatic logic [VAL_W-1:0] zz_unfold(logic [VAL_W-1:0] u);
        return (u >> 1) ^ {VAL_W{u[0]}};
    endfunction

    function automatic logic [VAL_W-1:0] sext_coord(logic [COORD_W-1:0] c);
        return {{(VAL_W-COORD_W){c[COORD_W-1]}}, c};
    endfunction

    // 66-bit sum cannot wrap, so the clamp test is exact
    function automatic logic [COORD_W-1:0] coord_add(logic [COORD_W-1:0] base,
                                                     logic [VAL_W-1:0] delta);
        logic signed [65:0] sum;
        sum = $signed({{2{delta[VAL_W-1]}}, delta})
            + $signed({{(66-COORD_W){base[COORD_W-1]}}, base});
        if (sum > SUM_MAX)
            return COORD_MAX;
        else if (sum < SUM_MIN)
            return COORD_MIN;
        return sum[COORD_W-1:0];
    endfunction

    task automatic derive_results(input in_item_t it);
        logic [VAL_W-1:0]   word;
        logic [VAL_W-1:0]   v;
        logic [VAL_W-1:0]   u;
        logic [COORD_W-1:0] c;
        out_item_t          r;
        word = it.value_in & WORD_MASK;
        c    = it.value_in[COORD_W-1:0];
        v    = '0;
        case (mode_t'(it.mode))
            MODE_ENC_RAW: v = word;
            MODE_ENC_ZZ:  v = zz_fold((word ^ WORD_SIGN) - WORD_SIGN) & WORD_MASK;
            MODE_ENC_X:
            begin
                v = zz_fold(sext_coord(c) - sext_coord(last_x));
                last_x = c;
            end
            MODE_ENC_Y:
            begin
                v = zz_fold(sext_coord(c) - sext_coord(last_y));
                last_y = c;
            end
            default:
            begin
                if (group_pos < WORD_BITS)
                begin
                    acc = (acc | (VAL_W'(it.byte_in[6:0]) << group_pos)) & WORD_MASK;
                    group_pos += GROUP_BITS;
                end
                if (!it.byte_in[7])
                begin
                    u         = acc;
                    acc       = '0;
                    group_pos = 0;
                    r          = '0;
                    r.is_value = 1'b1;
                    r.last     = 1'b1;
                    case (mode_t'(it.mode))
                        MODE_DEC_RAW: r.value_out = u;
                        MODE_DEC_ZZ:  r.value_out = zz_unfold(u) & WORD_MASK;
                        MODE_DEC_X:
                        begin
                            last_x = coord_add(last_x, zz_unfold(u));
                            r.value_out = sext_coord(last_x);
                        end
                        default:
                        begin
                            last_y = coord_add(last_y, zz_unfold(u));
                            r.value_out = sext_coord(last_y);
                        end
                    endcase
                    due_words.push_back(r);
                end
                return;
            end
        endcase
        // encode: low group first, bit 7 set on all but the final byte
        while (v >= VAL_W'(8'h80))
        begin
            r = '0;
            r.byte_out = {1'b1, v[6:0]};
            due_words.push_back(r);
            v = v >> GROUP_BITS;
        end
        r = '0;
        r.byte_out = v[BYTE_W-1:0];
        r.last     = 1'b1;
        due_words.push_back(r);
    endtask

    task automatic check_word(input out_item_t got);
        out_item_t want;
        if (due_words.size() == 0)
        begin
            fail_n++;
            if (fail_n <= 10)
                $display("unexpected word: is_value=%0b byte=%02h value=%016h last=%0b",
                         got.is_value, got.byte_out, got.value_out, got.last);
        end
        else
        begin
            want = due_words.pop_front();
            if (got !== want)
            begin
                fail_n++;
                if (fail_n <= 10)
                    $display({"word mismatch: exp is_value=%0b byte=%02h value=%016h last=%0b",
                              " | got is_value=%0b byte=%02h value=%016h last=%0b"},
                             want.is_value, want.byte_out, want.value_out, want.last,
                             got.is_value, got.byte_out, got.value_out, got.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x    = '0;
            last_y    = '0;
            acc       = '0;
            group_pos = 0;
            due_words.delete();
            waiting <= 0;
        end
        else
        begin
            // a word passes the queue and output registers before it shows, so popping first is safe
            if (pop && !empty)
                check_word(result);
            if (push && !full)
                derive_results(item);
            waiting    <= due_words.size();
            mismatches <= fail_n;
        end
    end

endmodule

### tb/sv/zigzag_varint_delta_codec_tb.sv
// Top of the varint codec testbench: clock, reset, stimulus and verdict.
// Depends on zvd_pkg, the codec RTL and zigzag_varint_delta_codec_checker.
module zigzag_varint_delta_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zvd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_CYCLES  = 250;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      push     = 1'b0;
    logic      pop      = 1'b0;
    in_item_t  item     = '0;
    logic      full;
    logic      empty;
    out_item_t result;
    int        mismatches;
    int        waiting;
    int        sent       = 0;
    int        burst_left = 0;
    int        rx_cycle   = 0;
    logic      hold_off   = 1'b0;

    always #5 clk = ~clk;

    zigzag_varint_delta_codec dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    zigzag_varint_delta_codec_checker check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    function automatic logic [VAL_W-1:0] rand_word();
        int               len;
        logic [VAL_W-1:0] w;
        len = $urandom_range(0, VAL_W);
        w   = {$urandom, $urandom};
        if (len < VAL_W)
            w &= (VAL_W'(1) << len) - 1;
        if ($urandom_range(0, 3) == 0)
            w = ~w;
        return w;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return COORD_W'($urandom_range(0, 255));
            3:       return -COORD_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // bursts of random length, random gaps between them
    task automatic send_word(input in_item_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic enc(input mode_t m, input logic [VAL_W-1:0] v);
        in_item_t w;
        w.mode     = m;
        w.value_in = v;
        w.byte_in  = BYTE_W'($urandom);
        send_word(w);
    endtask

    task automatic dec_byte(input mode_t m, input logic [BYTE_W-1:0] b);
        in_item_t w;
        w.mode     = m;
        w.value_in = {$urandom, $urandom};
        w.byte_in  = b;
        send_word(w);
    endtask

    task automatic enc_random();
        mode_t            m;
        logic [VAL_W-1:0] v;
        m = mode_t'($urandom_range(MODE_ENC_RAW, MODE_ENC_Y));
        if (m == MODE_ENC_X || m == MODE_ENC_Y)
            v = {$urandom, rand_coord()};
        else
            v = rand_word();
        enc(m, v);
    endtask

    // LEB128 byte string for u, with extra random groups for overlong input;
    // encodes may be slipped in between the bytes
    task automatic dec_seq(input logic [VAL_W-1:0] u, input mode_t fin, input int extra,
                           input bit mix);
        logic [BYTE_W-1:0] groups[$];
        int                k;
        do
        begin
            groups.push_back({1'b0, u[6:0]});
            u = u >> GROUP_BITS;
        end
        while (u != 0);
        repeat (extra) groups.push_back({1'b0, 7'($urandom)});
        for (k = 0; k < groups.size() - 1; k++)
        begin
            dec_byte(mode_t'($urandom_range(MODE_DEC_RAW, MODE_DEC_Y)), groups[k] | 8'h80);
            if (mix && $urandom_range(0, 5) == 0)
                enc_random();
        end
        dec_byte(fin, groups[groups.size() - 1]);
    endtask

    initial
    begin
        in_item_t noise;
        int       directed_n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        enc(MODE_ENC_RAW, 64'd0);
        enc(MODE_ENC_RAW, '1);
        enc(MODE_ENC_RAW, 64'd128);
        enc(MODE_ENC_ZZ, 64'h8000_0000_0000_0000);
        enc(MODE_ENC_ZZ, 64'h7FFF_FFFF_FFFF_FFFF);
        // widest coordinate deltas; upper half of value_in must be ignored
        enc(MODE_ENC_X, {32'hFFFF_FFFF, COORD_MAX});
        enc(MODE_ENC_X, {32'h0000_0000, COORD_MIN});
        enc(MODE_ENC_Y, {32'h1234_5678, COORD_MIN});
        dec_byte(MODE_DEC_RAW, 8'h00);
        dec_byte(MODE_DEC_ZZ, 8'h01);
        // encode between two bytes of one decode
        dec_byte(MODE_DEC_ZZ, 8'h81);
        enc(MODE_ENC_ZZ, '1);
        dec_byte(MODE_DEC_RAW, 8'h01);
        // x clamps low, then high
        dec_byte(MODE_DEC_X, 8'h01);
        enc(MODE_ENC_X, {32'h0000_0000, COORD_MAX});
        dec_byte(MODE_DEC_X, 8'h02);
        // eleven groups: bits past 63 dropped, y sum clamps
        repeat (10) dec_byte(MODE_DEC_RAW, 8'hFF);
        dec_byte(MODE_DEC_Y, 8'h7F);
        directed_n = sent;

        while (sent < directed_n + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    enc_random();
                9:
                begin
                    noise.mode     = 3'($urandom_range(MODE_ENC_RAW, MODE_DEC_Y));
                    noise.value_in = {$urandom, $urandom};
                    noise.byte_in  = BYTE_W'($urandom);
                    send_word(noise);
                end
                default:
                    dec_seq(rand_word(), mode_t'($urandom_range(MODE_DEC_RAW, MODE_DEC_Y)),
                            ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
            endcase
        end
        push <= 1'b0;

        // let the checker see the last accepted word before polling
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("zigzag_varint_delta_codec_tb OK");
        else
            $display("zigzag_varint_delta_codec_tb NOT OK");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering words
    initial
    begin
        wait (sent >= 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        logic ready;
        case ((rx_cycle / 97) % 4)
            0:       ready = 1'b1;
            1:       ready = ($urandom_range(0, 1) == 1);
            2:       ready = (rx_cycle % 3 == 0);
            default: ready = ($urandom_range(0, 4) == 0);
        endcase
        rx_cycle++;
        pop <= rst_n && !hold_off && ready;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("zigzag_varint_delta_codec_tb NOT OK");
        $finish;
    end

endmodule
